FILE: src/etfp_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and fixed-point helpers for the escape-time fractal pixel.
// Used by the controller, the datapath and the top level.
package etfp_pkg;

  localparam int FRAC_BITS = 28;
  localparam int Q_W       = FRAC_BITS + 4;
  localparam int COORD_W   = 12;
  localparam int ITER_W    = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DW    = 32;
  localparam int DIV_STEPS = COORD_W + FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef logic signed [Q_W-1:0] q_t;

  localparam q_t Q_MAX      = 32'sh7FFF_FFFF;
  localparam q_t Q_MIN      = 32'sh8000_0000;
  localparam q_t ONE_Q      = 32'sh1000_0000;
  localparam q_t QUARTER_Q  = 32'sh0400_0000;
  localparam q_t SIXTEENTH  = 32'sh0100_0000;
  localparam q_t FOUR_Q     = 32'sh4000_0000;
  localparam q_t SCALE_X    = 32'sh3800_0000;  // 3.5
  localparam q_t SCALE_Y    = 32'sh2000_0000;  // 2.0
  localparam q_t BASE_X_M   = 32'sh2800_0000;  // 2.5
  localparam q_t BASE_X_J   = 32'sh1C00_0000;  // 1.75
  localparam q_t BASE_Y     = 32'sh1000_0A7C;  // 1.00001 rounded down
  localparam q_t JULIA_CRE  = 32'sh05A5_E353;  // 0.353 rounded down
  localparam q_t JULIA_CIM  = 32'sh049B_A5E3;  // 0.288 rounded down

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZOOM   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_JULIA  = 3'd4;

  // Datapath operations.
  localparam logic [3:0] OP_NONE = 4'd0;
  localparam logic [3:0] OP_LOAD = 4'd1;
  localparam logic [3:0] OP_DIVX = 4'd2;
  localparam logic [3:0] OP_DIVY = 4'd3;
  localparam logic [3:0] OP_SPAN = 4'd4;
  localparam logic [3:0] OP_MAP  = 4'd5;
  localparam logic [3:0] OP_SUB  = 4'd6;
  localparam logic [3:0] OP_CHK1 = 4'd7;
  localparam logic [3:0] OP_CHK2 = 4'd8;
  localparam logic [3:0] OP_CHK3 = 4'd9;
  localparam logic [3:0] OP_ITA  = 4'd10;
  localparam logic [3:0] OP_ITB  = 4'd11;

  typedef struct packed {
    logic [3:0] op;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic early_zero;
    logic escaped;
  } dp_stat_t;

  function automatic q_t sat_add(input q_t a, input q_t b);
    logic signed [Q_W:0] s;
    s = {a[Q_W-1], a} + {b[Q_W-1], b};
    if (s[Q_W] != s[Q_W-1]) return s[Q_W] ? Q_MIN : Q_MAX;
    return s[Q_W-1:0];
  endfunction

  function automatic q_t sat_sub(input q_t a, input q_t b);
    logic signed [Q_W:0] s;
    s = {a[Q_W-1], a} - {b[Q_W-1], b};
    if (s[Q_W] != s[Q_W-1]) return s[Q_W] ? Q_MIN : Q_MAX;
    return s[Q_W-1:0];
  endfunction

  // Product rounded toward minus infinity, saturated.
  function automatic q_t mulq(input q_t a, input q_t b);
    logic signed [2*Q_W-1:0] p;
    logic signed [2*Q_W-1:0] s;
    p = a * b;
    s = p >>> FRAC_BITS;
    if (s[2*Q_W-1:Q_W-1] != {(Q_W+1){s[2*Q_W-1]}}) return s[2*Q_W-1] ? Q_MIN : Q_MAX;
    return s[Q_W-1:0];
  endfunction

endpackage

FILE: src/escape_time_fractal_pixel.sv
`timescale 1ns / 1ps
// Escape-time fractal pixel: one pixel coordinate in, one iteration count out.
// Time to out_valid grows with the orbit steps run: an item ends on an escape, on reaching
// the limit N, or with no orbit steps for a bulb or cardioid point; Julia mode skips those checks.
// The two 40-step coordinate divisions and the orbit step (S_ITA, S_ITB) set it.
// One item at a time; the next is taken while a result waits.
// Synchronous active-low reset clears control state and loads register defaults.
module escape_time_fractal_pixel (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [etfp_pkg::COORD_W-1:0]   in_pixel_col,
  input  logic [etfp_pkg::COORD_W-1:0]   in_pixel_row,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [etfp_pkg::ITER_W-1:0]    out_escape_count,
  input  logic                           cfg_wr_en,
  input  logic [etfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [etfp_pkg::CFG_DW-1:0]    cfg_wdata
);
  import etfp_pkg::*;

  logic [COORD_W-1:0] width_pixels_r, height_pixels_r;
  q_t                 zoom_factor_r;
  logic [ITER_W-1:0]  iteration_limit_r;
  logic               julia_select_r;
  dp_cmd_t            cmd;
  dp_stat_t           stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_pixels_r    <= COORD_W'(800);
      height_pixels_r   <= COORD_W'(600);
      zoom_factor_r     <= ONE_Q;
      iteration_limit_r <= ITER_W'(170);
      julia_select_r    <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_WIDTH:  width_pixels_r    <= cfg_wdata[COORD_W-1:0];
        REG_HEIGHT: height_pixels_r   <= cfg_wdata[COORD_W-1:0];
        REG_ZOOM:   zoom_factor_r     <= q_t'(cfg_wdata[Q_W-1:0]);
        REG_LIMIT:  iteration_limit_r <= cfg_wdata[ITER_W-1:0];
        REG_JULIA:  julia_select_r    <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  etfp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_escape_count(out_escape_count),
    .iteration_limit(iteration_limit_r), .julia_select(julia_select_r),
    .stat(stat), .cmd(cmd)
  );

  etfp_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_pixel_col(in_pixel_col), .in_pixel_row(in_pixel_row),
    .width_pixels(width_pixels_r), .height_pixels(height_pixels_r),
    .zoom_factor(zoom_factor_r), .julia_select(julia_select_r)
  );

  // A nonzero count is always below the limit it was run against.
  a_count_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_escape_count == '0) || (out_escape_count < iteration_limit_r))
    else $error("escape count not below iteration limit");

  // The divider only runs while an item is in flight.
  a_div_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    stat.div_busy |-> in_stall)
    else $error("divider running while input is open");

  // An accepted item closes the input for the next cycle.
  a_accept_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input open right after accepting an item");

endmodule

FILE: src/etfp_dp.sv
`timescale 1ns / 1ps
// Datapath: coordinate divider, three shared product registers (p0, p1, p2) and the orbit registers.
// Depends on etfp_pkg; driven by etfp_ctrl through dp_cmd_t.
module etfp_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  etfp_pkg::dp_cmd_t             cmd,
  output etfp_pkg::dp_stat_t            stat,
  input  logic [etfp_pkg::COORD_W-1:0]  in_pixel_col,
  input  logic [etfp_pkg::COORD_W-1:0]  in_pixel_row,
  input  logic [etfp_pkg::COORD_W-1:0]  width_pixels,
  input  logic [etfp_pkg::COORD_W-1:0]  height_pixels,
  input  etfp_pkg::q_t                  zoom_factor,
  input  logic                          julia_select
);
  import etfp_pkg::*;

  logic [COORD_W-1:0]   col_r, row_r;
  logic [DIV_STEPS-1:0] num_r, num_nxt;
  logic [COORD_W-1:0]   den_r, den_nxt;
  logic [COORD_W-1:0]   rem_r, rem_nxt;
  logic [Q_W-2:0]       quo_r, quo_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [DIV_CNT_W-1:0] dcnt_r, dcnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 axis_r, axis_nxt;

  q_t rx_r, rx_nxt, ry_r, ry_nxt;
  q_t p0_r, p0_nxt, p1_r, p1_nxt, p2_r, p2_nxt;
  q_t offx_r, offx_nxt, offy_r, offy_nxt;
  q_t x_r, x_nxt, y_r, y_nxt, cx_r, cx_nxt, cy_r, cy_nxt;
  q_t t_r, t_nxt, tq_r, tq_nxt, tqs_r, tqs_nxt;
  logic in1_r, in1_nxt;

  logic [COORD_W:0] rs;
  logic             ge;
  logic [Q_W-2:0]   qstep;
  logic             ostep;
  q_t               dres, zsel, px, py, q1, s;

  always_comb begin
    rs    = {rem_r, num_r[DIV_STEPS-1]};
    ge    = rs >= {1'b0, den_r};
    qstep = {quo_r[Q_W-3:0], ge};
    ostep = ovf_r | quo_r[Q_W-2];
    dres  = ostep ? Q_MAX : q_t'({1'b0, qstep});
    zsel  = julia_select ? ONE_Q : zoom_factor;
    px    = sat_sub(p0_r, offx_r);
    py    = sat_sub(p1_r, offy_r);
    q1    = sat_add(p2_r, p0_r);
    s     = sat_add(x_r, y_r);
  end

  always_comb begin
    num_nxt = num_r; den_nxt = den_r; rem_nxt = rem_r; quo_nxt = quo_r;
    ovf_nxt = ovf_r; dcnt_nxt = dcnt_r; busy_nxt = busy_r; axis_nxt = axis_r;
    rx_nxt = rx_r; ry_nxt = ry_r; p0_nxt = p0_r; p1_nxt = p1_r; p2_nxt = p2_r;
    offx_nxt = offx_r; offy_nxt = offy_r; x_nxt = x_r; y_nxt = y_r;
    cx_nxt = cx_r; cy_nxt = cy_r; t_nxt = t_r; tq_nxt = tq_r; tqs_nxt = tqs_r;
    in1_nxt = in1_r;

    // One quotient bit per cycle; a zero divisor sets every bit and overflows.
    if (busy_r) begin
      num_nxt  = {num_r[DIV_STEPS-2:0], 1'b0};
      rem_nxt  = ge ? COORD_W'(rs - {1'b0, den_r}) : rs[COORD_W-1:0];
      quo_nxt  = qstep;
      ovf_nxt  = ostep;
      dcnt_nxt = dcnt_r - 1'b1;
      if (dcnt_r == '0) begin
        busy_nxt = 1'b0;
        if (axis_r) ry_nxt = dres;
        else        rx_nxt = dres;
      end
    end

    case (cmd.op)
      OP_DIVX, OP_DIVY: begin
        axis_nxt = (cmd.op == OP_DIVY);
        num_nxt  = {(cmd.op == OP_DIVY) ? row_r : col_r, {FRAC_BITS{1'b0}}};
        den_nxt  = (cmd.op == OP_DIVY) ? height_pixels : width_pixels;
        rem_nxt  = '0;
        quo_nxt  = '0;
        ovf_nxt  = 1'b0;
        dcnt_nxt = DIV_CNT_W'(DIV_STEPS - 1);
        busy_nxt = 1'b1;
      end
      OP_SPAN: begin
        p0_nxt   = mulq(SCALE_X, zsel);
        p1_nxt   = mulq(SCALE_Y, zsel);
        offx_nxt = sat_sub(julia_select ? BASE_X_J : BASE_X_M, sat_sub(ONE_Q, zsel));
        offy_nxt = sat_sub(BASE_Y, sat_sub(ONE_Q, zsel));
      end
      OP_MAP: begin
        p0_nxt = mulq(rx_r, p0_r);
        p1_nxt = mulq(ry_r, p1_r);
      end
      OP_SUB: begin
        if (julia_select) begin
          x_nxt  = px;
          y_nxt  = py;
          cx_nxt = sat_add(JULIA_CRE, zoom_factor);
          cy_nxt = JULIA_CIM;
        end else begin
          x_nxt  = '0;
          y_nxt  = '0;
          cx_nxt = px;
          cy_nxt = py;
        end
      end
      OP_CHK1: begin
        p0_nxt = mulq(cy_r, cy_r);
        p1_nxt = mulq(sat_add(cx_r, ONE_Q), sat_add(cx_r, ONE_Q));
        t_nxt  = sat_sub(cx_r, QUARTER_Q);
        p2_nxt = mulq(sat_sub(cx_r, QUARTER_Q), sat_sub(cx_r, QUARTER_Q));
      end
      OP_CHK2: begin
        // Period-2 bulb test and the first half of the cardioid test.
        in1_nxt = sat_add(p1_r, p0_r) < SIXTEENTH;
        tq_nxt  = q1;
        tqs_nxt = sat_add(q1, t_r);
        p1_nxt  = mulq(QUARTER_Q, p0_r);
      end
      OP_CHK3: begin
        p2_nxt = mulq(tq_r, tqs_r);
      end
      OP_ITA: begin
        p0_nxt = mulq(x_r, x_r);
        p1_nxt = mulq(y_r, y_r);
        p2_nxt = mulq(s, s);
      end
      OP_ITB: begin
        y_nxt = sat_add(sat_sub(sat_sub(p2_r, p0_r), p1_r), cy_r);
        x_nxt = sat_add(sat_sub(p0_r, p1_r), cx_r);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      col_r <= in_pixel_col;
      row_r <= in_pixel_row;
    end
    num_r <= num_nxt; den_r <= den_nxt; rem_r <= rem_nxt; quo_r <= quo_nxt;
    ovf_r <= ovf_nxt; dcnt_r <= dcnt_nxt; axis_r <= axis_nxt;
    rx_r <= rx_nxt; ry_r <= ry_nxt; p0_r <= p0_nxt; p1_r <= p1_nxt; p2_r <= p2_nxt;
    offx_r <= offx_nxt; offy_r <= offy_nxt; x_r <= x_nxt; y_r <= y_nxt;
    cx_r <= cx_nxt; cy_r <= cy_nxt; t_r <= t_nxt; tq_r <= tq_nxt; tqs_r <= tqs_nxt;
    in1_r <= in1_nxt;
  end

  assign stat.div_busy   = busy_r;
  assign stat.early_zero = in1_r | (p2_r < p1_r);
  assign stat.escaped    = sat_add(p0_r, p1_r) > FOUR_Q;

endmodule

FILE: src/etfp_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences the datapath, counts iterations and holds the result register.
// Depends on etfp_pkg.
module etfp_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [etfp_pkg::ITER_W-1:0]  out_escape_count,
  input  logic [etfp_pkg::ITER_W-1:0]  iteration_limit,
  input  logic                         julia_select,
  input  etfp_pkg::dp_stat_t           stat,
  output etfp_pkg::dp_cmd_t            cmd
);
  import etfp_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIVX = 4'd1;
  localparam logic [3:0] S_WX   = 4'd2;
  localparam logic [3:0] S_DIVY = 4'd3;
  localparam logic [3:0] S_WY   = 4'd4;
  localparam logic [3:0] S_SPAN = 4'd5;
  localparam logic [3:0] S_MAP  = 4'd6;
  localparam logic [3:0] S_SUB  = 4'd7;
  localparam logic [3:0] S_CHK1 = 4'd8;
  localparam logic [3:0] S_CHK2 = 4'd9;
  localparam logic [3:0] S_CHK3 = 4'd10;
  localparam logic [3:0] S_CHK4 = 4'd11;
  localparam logic [3:0] S_ITA  = 4'd12;
  localparam logic [3:0] S_ITB  = 4'd13;
  localparam logic [3:0] S_DONE = 4'd14;

  logic [3:0]        state_r, state_nxt;
  logic [ITER_W-1:0] cnt_r, cnt_nxt;
  logic [ITER_W-1:0] res_r, res_nxt;
  logic              ovalid_r, ovalid_nxt;
  logic [ITER_W-1:0] ocount_r, ocount_nxt;

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    res_nxt    = res_r;
    ovalid_nxt = ovalid_r & out_stall;
    ocount_nxt = ocount_r;
    cmd.op     = OP_NONE;
    case (state_r)
      S_IDLE: if (in_valid) begin
        cmd.op    = OP_LOAD;
        state_nxt = S_DIVX;
      end
      S_DIVX: begin
        cmd.op    = OP_DIVX;
        state_nxt = S_WX;
      end
      S_WX: if (!stat.div_busy) state_nxt = S_DIVY;
      S_DIVY: begin
        cmd.op    = OP_DIVY;
        state_nxt = S_WY;
      end
      S_WY: if (!stat.div_busy) state_nxt = S_SPAN;
      S_SPAN: begin
        cmd.op    = OP_SPAN;
        state_nxt = S_MAP;
      end
      S_MAP: begin
        cmd.op    = OP_MAP;
        state_nxt = S_SUB;
      end
      S_SUB: begin
        cmd.op    = OP_SUB;
        cnt_nxt   = '0;
        state_nxt = julia_select ? S_ITA : S_CHK1;
      end
      S_CHK1: begin
        cmd.op    = OP_CHK1;
        state_nxt = S_CHK2;
      end
      S_CHK2: begin
        cmd.op    = OP_CHK2;
        state_nxt = S_CHK3;
      end
      S_CHK3: begin
        cmd.op    = OP_CHK3;
        state_nxt = S_CHK4;
      end
      S_CHK4: begin
        if (stat.early_zero) begin
          res_nxt   = '0;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_ITA;
        end
      end
      S_ITA: begin
        // Reaching the limit counts as inside.
        if (cnt_r >= iteration_limit) begin
          res_nxt   = '0;
          state_nxt = S_DONE;
        end else begin
          cmd.op    = OP_ITA;
          state_nxt = S_ITB;
        end
      end
      S_ITB: begin
        if (stat.escaped) begin
          res_nxt   = cnt_r;
          state_nxt = S_DONE;
        end else begin
          cmd.op    = OP_ITB;
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_ITA;
        end
      end
      S_DONE: if (!ovalid_r || !out_stall) begin
        ovalid_nxt = 1'b1;
        ocount_nxt = res_r;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r    <= cnt_nxt;
    res_r    <= res_nxt;
    ocount_r <= ocount_nxt;
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = ovalid_r;
  assign out_escape_count = ocount_r;

endmodule

FILE: tb/escape_time_fractal_pixel_test.sv
`timescale 1ns / 1ps
// Self-checking bench for escape_time_fractal_pixel: directed corners, random configuration
// phases under random stalls, and a long output hold-off. Depends on etfp_pkg and the RTL.
module escape_time_fractal_pixel_test;
  import etfp_pkg::*;

  localparam longint Q_HI = (longint'(1) <<< 31) - 1;
  localparam longint Q_LO = -(longint'(1) <<< 31);
  localparam longint Q_ONE = longint'(1) <<< 28;
  localparam int CYCLE_LIMIT = 20000000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [COORD_W-1:0] in_pixel_col;
  logic [COORD_W-1:0] in_pixel_row;
  logic out_valid;
  logic out_stall;
  logic [ITER_W-1:0] out_escape_count;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_wdata;

  escape_time_fractal_pixel uut (.*);

  // Shadow copy of the configuration registers.
  int unsigned width_px, height_px, iter_limit;
  longint zoom_q;
  bit julia_on;

  logic [ITER_W-1:0] pending_counts[$];
  int fail_count;
  int cycles;
  int send_idle_pct, recv_idle_pct, hold_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d counts outstanding", $time, pending_counts.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic longint clamp_q(input longint v);
    if (v > Q_HI) return Q_HI;
    if (v < Q_LO) return Q_LO;
    return v;
  endfunction

  function automatic longint fixed_mul(input longint a, input longint b);
    return clamp_q((a * b) >>> 28);
  endfunction

  function automatic longint fixed_ratio(input longint num, input longint den);
    if (den == 0 || num / den >= 8) return Q_HI;
    return (num <<< 28) / den;
  endfunction

  function automatic longint map_coord(input longint pos, input longint res, input longint zoom,
                                       input longint scale, input longint base);
    longint offset;
    offset = clamp_q(base - clamp_q(Q_ONE - zoom));
    return clamp_q(fixed_mul(fixed_ratio(pos, res), fixed_mul(scale, zoom)) - offset);
  endfunction

  function automatic int unsigned orbit_count(input longint x0, input longint y0,
                                              input longint cre, input longint cim);
    longint x, y, xx, yy, s;
    int unsigned n;
    x = x0;
    y = y0;
    n = 0;
    while (n < iter_limit) begin
      xx = fixed_mul(x, x);
      yy = fixed_mul(y, y);
      if (clamp_q(xx + yy) > (longint'(4) <<< 28)) break;
      s = clamp_q(x + y);
      y = clamp_q(clamp_q(clamp_q(fixed_mul(s, s) - xx) - yy) + cim);
      x = clamp_q(clamp_q(xx - yy) + cre);
      n++;
    end
    return (n >= iter_limit) ? 0 : n;
  endfunction

  function automatic logic [ITER_W-1:0] predict_count(input int unsigned col,
                                                      input int unsigned row);
    longint ybase, px, py, py2, xt, q, quarter;
    ybase = Q_ONE + fixed_ratio(1, 100000);
    quarter = Q_ONE >>> 2;
    if (julia_on) begin
      px = map_coord(col, width_px, Q_ONE, longint'(7) <<< 27, longint'(7) <<< 26);
      py = map_coord(row, height_px, Q_ONE, longint'(2) <<< 28, ybase);
      return orbit_count(px, py, clamp_q(fixed_ratio(353, 1000) + zoom_q),
                         fixed_ratio(288, 1000));
    end
    px = map_coord(col, width_px, zoom_q, longint'(7) <<< 27, longint'(5) <<< 27);
    py = map_coord(row, height_px, zoom_q, longint'(2) <<< 28, ybase);
    py2 = fixed_mul(py, py);
    xt = clamp_q(px + Q_ONE);
    // Period-2 bulb, then main cardioid.
    if (clamp_q(fixed_mul(xt, xt) + py2) < (Q_ONE >>> 4)) return '0;
    xt = clamp_q(px - quarter);
    q = clamp_q(fixed_mul(xt, xt) + py2);
    q = fixed_mul(q, clamp_q(q + xt));
    if (q < fixed_mul(quarter, py2)) return '0;
    return orbit_count(0, 0, px, py);
  endfunction

  // Result checker.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_counts.size() == 0) begin
        $display("%0t: unexpected count, expected none, actual %0d", $time, out_escape_count);
        fail_count++;
      end else begin
        if (out_escape_count !== pending_counts[0]) begin
          $display("%0t: escape_count mismatch, expected %0d, actual %0d", $time,
                   pending_counts[0], out_escape_count);
          fail_count++;
        end
        void'(pending_counts.pop_front());
      end
    end
  end

  // Receiver: random stalls, or a counted hold-off when one is requested.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall = 1'b1;
      end else begin
        out_stall = ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  task automatic send_pixel(input int unsigned col, input int unsigned row);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_pixel_col = col;
    in_pixel_row = row;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    pending_counts.push_back(predict_count(col, row));
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid = 1'b0;
    while (pending_counts.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_index = idx;
    cfg_wdata = data;
    cfg_wr_en = 1'b1;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    case (idx)
      REG_WIDTH:  width_px = data[11:0];
      REG_HEIGHT: height_px = data[11:0];
      REG_ZOOM:   zoom_q = longint'($signed(data));
      REG_LIMIT:  iter_limit = data[9:0];
      REG_JULIA:  julia_on = data[0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int unsigned w, input int unsigned h, input logic [31:0] z,
                            input int unsigned lim, input bit jul);
    drain();
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_ZOOM, z);
    write_reg(REG_LIMIT, lim);
    write_reg(REG_JULIA, jul);
  endtask

  task automatic test_defaults;
    send_pixel(0, 0);
    send_pixel(4095, 4095);
    send_pixel(400, 300);
    send_pixel(343, 300);
    send_pixel(800, 600);
    send_pixel(150, 100);
  endtask

  task automatic test_corner_settings;
    set_config(800, 600, 32'h1000_0000, 0, 1'b0);
    send_pixel(100, 50);
    set_config(0, 0, 32'h1000_0000, 20, 1'b0);
    send_pixel(0, 0);
    send_pixel(4095, 1);
    set_config(4095, 4095, 32'h8000_0000, 1023, 1'b0);
    send_pixel(0, 4095);
    send_pixel(2048, 2048);
    set_config(1, 1, 32'h7FFF_FFFF, 1, 1'b0);
    send_pixel(0, 0);
    send_pixel(1, 1);
    set_config(800, 600, 32'h0000_0000, 170, 1'b1);
    send_pixel(0, 0);
    send_pixel(400, 300);
    send_pixel(4095, 0);
    set_config(640, 480, 32'hF000_0000, 1023, 1'b1);
    send_pixel(320, 240);
    send_pixel(10, 470);
  endtask

  task automatic random_phase(input int items);
    int unsigned w, h, col, row;
    logic [31:0] z;
    w = ($urandom_range(3) == 0) ? $urandom_range(1, 4095) : $urandom_range(16, 1200);
    h = ($urandom_range(3) == 0) ? $urandom_range(1, 4095) : $urandom_range(16, 900);
    z = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(32'h0200_0000, 32'h1800_0000);
    set_config(w, h, z, $urandom_range(1, 200), $urandom_range(1));
    repeat (items) begin
      if ($urandom_range(4) == 0) begin
        col = $urandom_range(4095);
        row = $urandom_range(4095);
      end else begin
        col = $urandom_range(w);
        row = $urandom_range(h);
      end
      send_pixel(col, row);
    end
  endtask

  task automatic test_random_traffic;
    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 37 : (mode == 1) ? 62 : 0;
      recv_idle_pct = (mode == 0) ? 62 : (mode == 1) ? 37 : 0;
      repeat (4) random_phase(65);
    end
    // A few items at the largest limit.
    set_config(800, 600, 32'h1000_0000, 1023, 1'b0);
    repeat (6) send_pixel($urandom_range(4095), $urandom_range(4095));
  endtask

  task automatic test_output_hold;
    set_config(320, 240, 32'h1000_0000, 40, 1'b0);
    hold_cycles = 600;
    repeat (8) send_pixel($urandom_range(320), $urandom_range(240));
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_pixel_col = '0;
    in_pixel_row = '0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles = 0;
    fail_count = 0;
    cycles = 0;
    width_px = 800;
    height_px = 600;
    zoom_q = Q_ONE;
    iter_limit = 170;
    julia_on = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_defaults();
    test_corner_settings();
    test_random_traffic();
    test_output_hold();
    drain();
    repeat (100) @(negedge clk);

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
